// ===== hdl/supq_pkg.sv =====
// Shared types and codes for the sorted unique priority queue.
package supq_pkg;

  localparam int unsigned PrioW = 16;
  localparam int unsigned PayloadW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OccW = 5;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef struct packed {
    logic load;     // capture the accepted word
    logic compare;  // per-entry compare, flags registered
    logic update;   // shift / insert / pop and load the result register
  } cmd_t;

endpackage

// ===== hdl/supq_if.sv =====
// Valid/ready channel interfaces for queue commands and results.
interface supq_in_if
  import supq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [PrioW-1:0]    prio;
  logic        [PayloadW-1:0] payload;

  modport source (output valid, mode, prio, payload, input ready);
  modport sink   (input valid, mode, prio, payload, output ready);
endinterface

interface supq_out_if
  import supq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic        [StatusW-1:0]  status;
  logic        [PayloadW-1:0] out_payload;
  logic signed [PrioW-1:0]    out_prio;
  logic        [OccW-1:0]     occupancy;

  modport source (output valid, status, out_payload, out_prio, occupancy, input ready);
  modport sink   (input valid, status, out_payload, out_prio, occupancy, output ready);
endinterface

// ===== hdl/supq_ctrl.sv =====
// Sequencer: accept, compare, update, then hold the result word until taken.
module supq_ctrl
  import supq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.load    = accept;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.update  = (state_q == S_UPD);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CMP;
      S_CMP:   state_d = S_UPD;
      S_UPD:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_UPD) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/supq_datapath.sv =====
// Sorted entry row with per-entry compare, shift network and result register.
module supq_datapath
  import supq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  input  logic                       mode_i,
  input  logic signed [PrioW-1:0]    prio_i,
  input  logic        [PayloadW-1:0] payload_i,
  output logic        [StatusW-1:0]  status_o,
  output logic        [PayloadW-1:0] out_payload_o,
  output logic signed [PrioW-1:0]    out_prio_o,
  output logic        [OccW-1:0]     occupancy_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                       mode_q;
  logic signed [PrioW-1:0]    prio_q;
  logic        [PayloadW-1:0] payload_q;

  logic signed [PrioW-1:0]    cell_prio_q [DEPTH];
  logic        [PayloadW-1:0] cell_pl_q   [DEPTH];
  logic        [DEPTH-1:0]    below_q;
  logic        [DEPTH-1:0]    eq_q;

  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     count_ext;

  status_e                    res_status_d;
  logic        [StatusW-1:0]  res_status_q;
  logic        [PayloadW-1:0] res_payload_q;
  logic signed [PrioW-1:0]    res_prio_q;
  logic        [OccW-1:0]     res_occ_q;

  logic dup, full, empty, do_ins, do_pop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      prio_q    <= prio_i;
      payload_q <= payload_i;
    end
  end

  assign dup    = |eq_q;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign do_ins = cmd_i.update && (mode_q == MODE_INSERT) && !dup && !full;
  assign do_pop = cmd_i.update && (mode_q == MODE_REMOVE) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic held;
    assign held = (CntW'(i) < count_q);

    // below: slot is free or holds a lower priority (a thermometer for sorted data)
    always_ff @(posedge clk_i) begin
      if (cmd_i.compare) begin
        below_q[i] <= !held || (cell_prio_q[i] < prio_q);
        eq_q[i]    <= held && (cell_prio_q[i] == prio_q);
      end
    end

    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        if (i == 0) begin
          if (below_q[i]) begin
            cell_prio_q[i] <= prio_q;
            cell_pl_q[i]   <= payload_q;
          end
        end else if (below_q[i]) begin
          if (!below_q[(i == 0) ? 0 : i-1]) begin
            cell_prio_q[i] <= prio_q;
            cell_pl_q[i]   <= payload_q;
          end else begin
            cell_prio_q[i] <= cell_prio_q[(i == 0) ? 0 : i-1];
            cell_pl_q[i]   <= cell_pl_q[(i == 0) ? 0 : i-1];
          end
        end
      end else if (do_pop && (i < DEPTH - 1)) begin
        cell_prio_q[i] <= cell_prio_q[(i < DEPTH - 1) ? i+1 : i];
        cell_pl_q[i]   <= cell_pl_q[(i < DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    res_status_d = ST_INSERTED;
    if (mode_q == MODE_INSERT) begin
      if (dup) begin
        res_status_d = ST_DUPLICATE;
      end else if (full) begin
        res_status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        res_status_d = ST_EMPTY;
      end else begin
        res_status_d = ST_REMOVED;
        count_d      = count_q - CntW'(1);
      end
    end
  end

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.update) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      res_status_q  <= res_status_d;
      res_occ_q     <= count_ext[OccW-1:0];
      res_payload_q <= do_pop ? cell_pl_q[0] : '0;
      res_prio_q    <= do_pop ? cell_prio_q[0] : '0;
    end
  end

  assign status_o      = res_status_q;
  assign out_payload_o = res_payload_q;
  assign out_prio_o    = res_prio_q;
  assign occupancy_o   = res_occ_q;

endmodule

// ===== hdl/sorted_unique_priority_queue.sv =====
// Sorted unique priority queue: DEPTH entries in descending signed priority,
// each priority at most once. A command word is captured, then every entry
// compares itself against the new priority at once, then for an insert the
// entries from the insertion point on shift down one place, for a pop the
// whole row shifts up one place, and the result word is registered. The
// result register is freed when its word is taken, and a new command is
// accepted in that same cycle; none is accepted during compare or update.
// There is no clearing pass after reset; the queue is ready at once.
module sorted_unique_priority_queue
  import supq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  supq_in_if.sink     in_i,
  supq_out_if.source  out_o
);

  cmd_t cmd;

  supq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  supq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (in_i.mode),
    .prio_i        (in_i.prio),
    .payload_i     (in_i.payload),
    .status_o      (out_o.status),
    .out_payload_o (out_o.out_payload),
    .out_prio_o    (out_o.out_prio),
    .occupancy_o   (out_o.occupancy)
  );

endmodule
